[rtl/first_fit_page_and_slice_allocator_top_assert.svh]
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_PAGE_AND_SLICE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_PAGE_AND_SLICE_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define FFPSA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under reset.
`define FFPSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ffpsa_pkg.sv]
// Package: sizes, codes, payload types and helpers for the page/slice allocator.
`default_nettype none
package ffpsa_pkg;
	localparam int MAX_EXTENTS     = 16;
	localparam int SLICE_DEPTH     = 64;
	localparam int PAGE_NUM_BITS   = 20;
	localparam int PAGE_LOG2       = 12;
	localparam int SLICE_LOG2      = 10;
	localparam int SLICES_PER_PAGE = 4;
	localparam int KIB_SHIFT       = PAGE_LOG2 - SLICE_LOG2;

	localparam int REQ_W   = 3;
	localparam int ADDR_W  = 22;
	localparam int CNT_W   = 21;
	localparam int ST_W    = 3;
	localparam int PAGES_W = PAGE_NUM_BITS + 1;
	localparam int CMP_W   = (CNT_W > PAGES_W) ? CNT_W : PAGES_W;
	localparam int EIDX_W  = $clog2(MAX_EXTENTS);
	localparam int ECNT_W  = $clog2(MAX_EXTENTS + 1);
	localparam int SIDX_W  = $clog2(SLICE_DEPTH);
	localparam int SCNT_W  = $clog2(SLICE_DEPTH + 1);
	localparam int K_W     = $clog2(SLICES_PER_PAGE);

	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PALLOC = 3'd1;
	localparam logic [REQ_W-1:0] REQ_PFREE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SALLOC = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SFREE  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NOMEM   = 3'd1;
	localparam logic [ST_W-1:0] ST_TFULL   = 3'd2;
	localparam logic [ST_W-1:0] ST_IGNORED = 3'd3;
	localparam logic [ST_W-1:0] ST_SFULL   = 3'd4;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ADDR_W-1:0] addr_kib;
		logic [CNT_W-1:0]  page_count;
	} req_item_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] result_addr_kib;
	} rsp_item_t;

	typedef struct packed {
		logic [PAGE_NUM_BITS-1:0] base;
		logic [PAGES_W-1:0]       pages;
	} ext_entry_t;

	localparam int EXT_W = $bits(ext_entry_t);

	typedef struct packed {
		logic              we;
		logic [EIDX_W-1:0] waddr;
		ext_entry_t        wdata;
		logic [EIDX_W-1:0] raddr;
	} ext_port_t;

	typedef struct packed {
		logic              we;
		logic [SIDX_W-1:0] waddr;
		logic [ADDR_W-1:0] wdata;
		logic [SIDX_W-1:0] raddr;
	} slc_port_t;

	function automatic logic [PAGE_NUM_BITS-1:0] page_of(input logic [ADDR_W-1:0] a);
		logic [63:0] t;
		t = 64'(a) >> KIB_SHIFT;
		return t[PAGE_NUM_BITS-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] page_kib(input logic [PAGE_NUM_BITS-1:0] p);
		logic [63:0] t;
		t = 64'(p) << KIB_SHIFT;
		return t[ADDR_W-1:0];
	endfunction
endpackage
`default_nettype wire

[rtl/ffpsa_ram.sv]
// Generic simple dual-port RAM, one write port, registered read.
`default_nettype none
module ffpsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/ffpsa_engine.sv]
// Request sequencer: extent search, shift, write-back and slice store control.
`default_nettype none
module ffpsa_engine (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire ffpsa_pkg::req_item_t  req_data,
	output logic                       res_valid,
	output ffpsa_pkg::rsp_item_t       res_data,
	input  wire logic                  res_take,
	output ffpsa_pkg::ext_port_t       ext,
	input  wire ffpsa_pkg::ext_entry_t ext_rd,
	output ffpsa_pkg::slc_port_t       slc,
	input  wire logic [ffpsa_pkg::ADDR_W-1:0] slc_rd
);
	import ffpsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_SRCH, S_EVAL, S_MOVE, S_WFIN, S_SLW, S_SRD, S_DONE
	} state_t;

	state_t             state_q;
	req_item_t          req_q;
	logic [ECNT_W-1:0]  ecnt_q, i_q, pos_q, mv_left_q;
	logic [SCNT_W-1:0]  scnt_q;
	logic               found_q, mv_up_q, pend_q, fin_en_q, inc_q, dec_q;
	ext_entry_t         prev_q, cur_q, fin_data_q;
	logic [EIDX_W-1:0]  mv_rd_q, pend_addr_q, fin_addr_q;
	logic [PAGE_NUM_BITS-1:0] got_q;
	logic [K_W-1:0]     k_q;
	rsp_item_t          res_q;

	logic [PAGE_NUM_BITS-1:0] page;
	logic [CNT_W-1:0]   need;
	logic [PAGES_W-1:0] room, clip;
	logic               hit, in_range, sfree_ok;
	logic [ECNT_W-1:0]  cm1, pp1, pm1;
	logic [PAGE_NUM_BITS+1:0] prev_end;
	logic               has_prev, join_prev, join_next, chain;
	logic [PAGES_W-1:0] merged;
	logic [SCNT_W-1:0]  sm1;

	always_comb begin
		page     = page_of(req_q.addr_kib);
		need     = (req_q.req_type == REQ_SALLOC) ? CNT_W'(1) : req_q.page_count;
		room     = {1'b1, {PAGE_NUM_BITS{1'b0}}} - {1'b0, page};
		clip     = (CMP_W'(req_q.page_count) > CMP_W'(room)) ? room
			: PAGES_W'(req_q.page_count);
		in_range = i_q < ecnt_q;
		if (req_q.req_type == REQ_ADD || req_q.req_type == REQ_PFREE) begin
			hit = ext_rd.base >= page;
		end else begin
			hit = CMP_W'(ext_rd.pages) >= CMP_W'(need);
		end
		cm1       = ecnt_q - ECNT_W'(1);
		pp1       = pos_q + ECNT_W'(1);
		pm1       = pos_q - ECNT_W'(1);
		prev_end  = (PAGE_NUM_BITS+2)'(prev_q.base) + (PAGE_NUM_BITS+2)'(prev_q.pages);
		has_prev  = pos_q != '0;
		join_prev = has_prev && (prev_end == (PAGE_NUM_BITS+2)'(page));
		chain     = found_q && (prev_end + 1'b1 == (PAGE_NUM_BITS+2)'(cur_q.base));
		join_next = found_q
			&& ((PAGE_NUM_BITS+1)'(page) + 1'b1 == (PAGE_NUM_BITS+1)'(cur_q.base));
		merged    = PAGES_W'((PAGES_W+1)'(prev_q.pages) + (PAGES_W+1)'(cur_q.pages)
			+ (PAGES_W+1)'(1));
		sm1       = scnt_q - SCNT_W'(1);
		sfree_ok  = req_q.addr_kib != '0 && scnt_q < SCNT_W'(SLICE_DEPTH);
	end

	always_comb begin
		ext = '0;
		unique case (state_q)
			S_SRCH: ext.raddr = EIDX_W'(i_q + ECNT_W'(1));
			S_MOVE: begin
				ext.raddr = mv_rd_q;
				ext.we    = pend_q;
				ext.waddr = pend_addr_q;
				ext.wdata = ext_rd;
			end
			S_WFIN: begin
				ext.we    = fin_en_q;
				ext.waddr = fin_addr_q;
				ext.wdata = fin_data_q;
			end
			default: ext.raddr = '0;
		endcase
	end

	always_comb begin
		slc       = '0;
		slc.raddr = sm1[SIDX_W-1:0];
		unique case (state_q)
			S_DEC: begin
				slc.we    = req_q.req_type == REQ_SFREE && sfree_ok;
				slc.waddr = scnt_q[SIDX_W-1:0];
				slc.wdata = req_q.addr_kib;
			end
			S_SLW: begin
				slc.we    = 1'b1;
				slc.waddr = SIDX_W'(k_q);
				slc.wdata = page_kib(got_q) + ADDR_W'(k_q);
			end
			default: slc.we = 1'b0;
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ecnt_q  <= '0;
			scnt_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req_data;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_q.result_addr_kib <= '0;
					res_q.status          <= ST_IGNORED;
					i_q                   <= '0;
					state_q               <= S_DONE;
					unique case (req_q.req_type)
						REQ_ADD: begin
							if (req_q.page_count == '0) begin
								res_q.status <= ST_IGNORED;
							end else if (ecnt_q >= ECNT_W'(MAX_EXTENTS)) begin
								res_q.status <= ST_TFULL;
							end else begin
								state_q <= S_SRCH;
							end
						end
						REQ_PALLOC: begin
							if (req_q.page_count != '0) state_q <= S_SRCH;
						end
						REQ_PFREE: begin
							if (page != '0) state_q <= S_SRCH;
						end
						REQ_SALLOC: begin
							state_q <= (scnt_q == '0) ? S_SRCH : S_SRD;
						end
						REQ_SFREE: begin
							if (req_q.addr_kib == '0) begin
								res_q.status <= ST_IGNORED;
							end else if (!sfree_ok) begin
								res_q.status <= ST_SFULL;
							end else begin
								res_q.status <= ST_OK;
								scnt_q       <= scnt_q + SCNT_W'(1);
							end
						end
						default: res_q.status <= ST_IGNORED;
					endcase
				end
				S_SRCH: begin
					// one entry per cycle; prev_q trails by one for merges
					if (!in_range || hit) begin
						pos_q   <= i_q;
						found_q <= in_range;
						cur_q   <= ext_rd;
						state_q <= S_EVAL;
					end else begin
						prev_q <= ext_rd;
						i_q    <= i_q + ECNT_W'(1);
					end
				end
				S_EVAL: begin
					mv_left_q <= '0;
					mv_up_q   <= 1'b0;
					mv_rd_q   <= pp1[EIDX_W-1:0];
					pend_q    <= 1'b0;
					fin_en_q  <= 1'b0;
					inc_q     <= 1'b0;
					dec_q     <= 1'b0;
					res_q.status <= ST_OK;
					state_q   <= S_MOVE;
					unique case (req_q.req_type)
						REQ_ADD: begin
							mv_left_q  <= ecnt_q - pos_q;
							mv_rd_q    <= cm1[EIDX_W-1:0];
							mv_up_q    <= 1'b1;
							fin_en_q   <= 1'b1;
							fin_addr_q <= pos_q[EIDX_W-1:0];
							fin_data_q <= '{base: page, pages: clip};
							inc_q      <= 1'b1;
						end
						REQ_PFREE: begin
							if (join_prev) begin
								fin_en_q   <= 1'b1;
								fin_addr_q <= pm1[EIDX_W-1:0];
								if (chain) begin
									fin_data_q <= '{base: prev_q.base, pages: merged};
									mv_left_q  <= cm1 - pos_q;
									dec_q      <= 1'b1;
								end else begin
									fin_data_q <= '{base: prev_q.base,
										pages: prev_q.pages + PAGES_W'(1)};
								end
							end else if (join_next) begin
								fin_en_q   <= 1'b1;
								fin_addr_q <= pos_q[EIDX_W-1:0];
								fin_data_q <= '{base: page, pages: cur_q.pages + PAGES_W'(1)};
							end else if (ecnt_q >= ECNT_W'(MAX_EXTENTS)) begin
								res_q.status <= ST_TFULL;
								state_q      <= S_DONE;
							end else begin
								mv_left_q  <= ecnt_q - pos_q;
								mv_rd_q    <= cm1[EIDX_W-1:0];
								mv_up_q    <= 1'b1;
								fin_en_q   <= 1'b1;
								fin_addr_q <= pos_q[EIDX_W-1:0];
								fin_data_q <= '{base: page, pages: PAGES_W'(1)};
								inc_q      <= 1'b1;
							end
						end
						default: begin
							// page alloc, also the refill path of a slice alloc
							if (!found_q) begin
								res_q.status <= ST_NOMEM;
								state_q      <= S_DONE;
							end else begin
								got_q <= cur_q.base;
								if (req_q.req_type == REQ_PALLOC) begin
									res_q.result_addr_kib <= page_kib(cur_q.base);
								end
								if (CMP_W'(cur_q.pages) == CMP_W'(need)) begin
									mv_left_q <= cm1 - pos_q;
									dec_q     <= 1'b1;
								end else begin
									fin_en_q   <= 1'b1;
									fin_addr_q <= pos_q[EIDX_W-1:0];
									fin_data_q <= '{
										base:  PAGE_NUM_BITS'(64'(cur_q.base) + 64'(need)),
										pages: PAGES_W'(CMP_W'(cur_q.pages) - CMP_W'(need))};
								end
							end
						end
					endcase
				end
				S_MOVE: begin
					// read one entry per cycle, write it one slot over the next cycle
					if (mv_left_q != '0) begin
						pend_q      <= 1'b1;
						pend_addr_q <= mv_up_q ? mv_rd_q + EIDX_W'(1) : mv_rd_q - EIDX_W'(1);
						mv_rd_q     <= mv_up_q ? mv_rd_q - EIDX_W'(1) : mv_rd_q + EIDX_W'(1);
						mv_left_q   <= mv_left_q - ECNT_W'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) state_q <= S_WFIN;
					end
				end
				S_WFIN: begin
					if (inc_q) begin
						ecnt_q <= ecnt_q + ECNT_W'(1);
					end else if (dec_q) begin
						ecnt_q <= cm1;
					end
					k_q     <= '0;
					state_q <= (req_q.req_type == REQ_SALLOC) ? S_SLW : S_DONE;
				end
				S_SLW: begin
					if (k_q == K_W'(SLICES_PER_PAGE - 2)) begin
						scnt_q                <= SCNT_W'(SLICES_PER_PAGE - 1);
						res_q.result_addr_kib <= page_kib(got_q)
							+ ADDR_W'(SLICES_PER_PAGE - 1);
						state_q               <= S_DONE;
					end else begin
						k_q <= k_q + K_W'(1);
					end
				end
				S_SRD: begin
					res_q.status          <= ST_OK;
					res_q.result_addr_kib <= slc_rd;
					scnt_q                <= sm1;
					state_q               <= S_DONE;
				end
				S_DONE: begin
					if (res_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/first_fit_page_and_slice_allocator_top.sv]
// Top level: first-fit page extent and 1 KiB slice allocator.
//
// Request channel (req_valid / req_stall / req_data): one transaction per
// request; req_stall is high while a request is being worked on.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one
// transaction per request, in request order.
//
// The extent table sits in a single-read-port RAM, so the first-fit search
// reads one entry per cycle, then a sorted insert or removal moves the
// entries behind the hit one per cycle. A slice alloc that refills from a
// page writes 3 of its slices into the slice store. The next request is
// accepted in the cycle after the result moves to the output register, so a
// stalled receiver costs nothing until a second result waits.
// Reset (arst_n low) empties the extent table and the slice store by
// clearing their counts; the RAMs themselves are never swept.
// While rsp_stall is high the response register holds its transaction.
`default_nettype none
module first_fit_page_and_slice_allocator_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire ffpsa_pkg::req_item_t req_data,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output ffpsa_pkg::rsp_item_t      rsp_data
);
	import ffpsa_pkg::*;

	ext_port_t         ext;
	ext_entry_t        ext_rd;
	logic [EXT_W-1:0]  ext_rd_raw;
	slc_port_t         slc;
	logic [ADDR_W-1:0] slc_rd;
	logic              res_valid, res_take;
	rsp_item_t         res_data;
	logic              rsp_valid_q;
	rsp_item_t         rsp_data_q;

	// extent table: {base page, length}
	ffpsa_ram #(.WIDTH(EXT_W), .DEPTH(MAX_EXTENTS)) u_ext_ram (
		.clk   (clk),
		.we    (ext.we),
		.waddr (ext.waddr),
		.wdata (ext.wdata),
		.raddr (ext.raddr),
		.rdata (ext_rd_raw)
	);
	assign ext_rd = ext_entry_t'(ext_rd_raw);

	// LIFO slice store
	ffpsa_ram #(.WIDTH(ADDR_W), .DEPTH(SLICE_DEPTH)) u_slc_ram (
		.clk   (clk),
		.we    (slc.we),
		.waddr (slc.waddr),
		.wdata (slc.wdata),
		.raddr (slc.raddr),
		.rdata (slc_rd)
	);

	ffpsa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_take  (res_take),
		.ext       (ext),
		.ext_rd    (ext_rd),
		.slc       (slc),
		.slc_rd    (slc_rd)
	);

	// output register decouples the engine from a stalling receiver
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_data_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;
endmodule
`default_nettype wire

[rtl/ffpsa_checker.sv]
// Port-level checker for the allocator top level, with its bind.
`default_nettype none
`include "first_fit_page_and_slice_allocator_top_assert.svh"
module ffpsa_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_stall,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_stall,
	input wire ffpsa_pkg::rsp_item_t rsp_data
);
	import ffpsa_pkg::*;

	`FFPSA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled response changed")
	`FFPSA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall, "request side not busy after accept")
	`FFPSA_ASSERT_NOW(a_err_no_addr, clk, arst_n, rsp_valid && rsp_data.status != ST_OK, rsp_data.result_addr_kib == '0, "failed request returned an address")
	`FFPSA_ASSERT_NOW(a_rsp_from_busy, clk, arst_n, $rose(rsp_valid), $past(req_stall), "response without request in flight")
endmodule

bind first_fit_page_and_slice_allocator_top ffpsa_checker u_ffpsa_checker (.*);
`default_nettype wire
